// File: hdl/grouped_stream_reducer_defines.svh
// Assertion macros for the grouped stream reducer.
// Included by modules that check their own control logic; no other dependencies.
`ifndef GROUPED_STREAM_REDUCER_DEFINES_SVH
`define GROUPED_STREAM_REDUCER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising edge of clk, suspended while arst_n is low.
`define GSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property on every rising edge of clk, also during reset.
`define GSR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GSR_ASSERT(label, prop, msg)
`define GSR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/gsr_pkg.sv
// Shared types and constants for the grouped stream reducer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package gsr_pkg;

	localparam int SAMPLE_WIDTH    = 32;
	localparam int ACC_WIDTH       = 64;
	localparam int OUT_WIDTH       = 32;
	localparam int ROOT_WIDTH      = ACC_WIDTH / 2;
	localparam int ROOT_STEPS      = ROOT_WIDTH;
	localparam int STEP_WIDTH      = $clog2(ROOT_STEPS);
	localparam int REM_WIDTH       = ROOT_WIDTH + 3;
	localparam int GROUP_WIDTH     = 16;
	localparam int MODE_WIDTH      = 3;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE       = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GROUP_SIZE = CFG_INDEX_WIDTH'(1);

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_SUM      = 3'd0,
		MODE_MAX      = 3'd1,
		MODE_MIN      = 3'd2,
		MODE_ABSMAX   = 3'd3,
		MODE_ABSMIN   = 3'd4,
		MODE_RSS      = 3'd5,
		MODE_FIRSTABS = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACC,
		ST_RINIT,
		ST_ROOT,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           vector_end;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] reduced;
		logic                        last_group;
	} out_item_t;

	typedef struct packed {
		logic load_in;
		logic square;
		logic accum;
		logic root_init;
		logic root_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic group_end;
		logic rss;
		logic root_done;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/grouped_stream_reducer.sv
// Top level of the grouped stream reducer: configuration registers,
// controller and datapath. Depends on gsr_pkg, gsr_ctrl and gsr_datapath.
//
// Reduces a stream of signed Q16.16 samples to one result per group of group_size samples
// (group_size 0: one group per vector; a sample with vector_end closes the vector and its
// partial group). Modes: sum, max, min, absmax, absmin, root sum of squares, first absolute;
// max seeds each group with the absolute value of its first sample, min with the sample itself.
// The accumulator is 64 bits and saturates; every result saturates to 32 bits. Each request
// passes through accept, square and accumulate. A request that closes a group then loads the
// output register; in root-sum-of-squares mode it first waits while the square root of the
// accumulator is computed by a restoring unit that resolves one result bit per cycle. The
// output register frees the input side: a finished result may wait for out_ready while the
// next request is taken, and the block stalls only when a second result is ready behind it.
// Write mode (index 0) and group_size (index 1) only while the block is idle; cfg_ready is
// always high and writes to other indexes are dropped.
`default_nettype none

module grouped_stream_reducer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire gsr_pkg::in_item_t                     in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output gsr_pkg::out_item_t                         out_data,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [gsr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [gsr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
	import gsr_pkg::*;

	mode_t                  mode_q;
	logic [GROUP_WIDTH-1:0] group_size_q;
	dp_cmd_t                cmd;
	dp_status_t             sts;

	// Configuration is always writable; decode the index and drop unknown ones.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SUM;
			group_size_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:       mode_q       <= mode_t'(cfg_data[MODE_WIDTH-1:0]);
				CFG_GROUP_SIZE: group_size_q <= cfg_data[GROUP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Controller: one request at a time, sequenced through the datapath.
	gsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: accumulator, group counter, square root and result register.
	gsr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode_q),
		.group_size (group_size_q),
		.in_data    (in_data),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// File: hdl/gsr_datapath.sv
// Datapath of the grouped stream reducer: sample register, squarer,
// accumulator, group counter, bit-serial square root and result register. Uses gsr_pkg.
`default_nettype none

module gsr_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gsr_pkg::dp_cmd_t                   cmd,
	output gsr_pkg::dp_status_t                     sts,
	input  wire gsr_pkg::mode_t                     mode,
	input  wire logic [gsr_pkg::GROUP_WIDTH-1:0]    group_size,
	input  wire gsr_pkg::in_item_t                  in_data,
	output gsr_pkg::out_item_t                      out_data
);
	import gsr_pkg::*;

	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
	localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

	logic signed [ACC_WIDTH-1:0]  x_q;
	logic                         vend_q;
	logic [ACC_WIDTH-1:0]         sq_q;
	logic [ACC_WIDTH-1:0]         acc_q;
	logic [GROUP_WIDTH-1:0]       cnt_q;
	logic [ACC_WIDTH-1:0]         rad_q;
	logic [REM_WIDTH-1:0]         rem_q;
	logic [ROOT_WIDTH-1:0]        root_q;
	logic [STEP_WIDTH-1:0]        step_q;
	out_item_t                    out_q;

	logic [ACC_WIDTH-1:0]         mag;
	logic [ACC_WIDTH-1:0]         sq_d;
	logic [ACC_WIDTH-1:0]         acc_d;
	logic                         gend;
	logic [REM_WIDTH-1:0]         rem_sh;
	logic [REM_WIDTH-1:0]         trial;
	logic [OUT_WIDTH-1:0]         sat_acc;
	logic [OUT_WIDTH-1:0]         sat_root;

	// Magnitude and saturating square of the held sample.
	always_comb begin
		mag = x_q[ACC_WIDTH-1] ? ACC_WIDTH'(-x_q) : ACC_WIDTH'(x_q);
		if (|mag[ACC_WIDTH-1:ROOT_WIDTH]) begin
			sq_d = '1;
		end else begin
			sq_d = ACC_WIDTH'(mag[ROOT_WIDTH-1:0] * mag[ROOT_WIDTH-1:0]);
		end
	end

	// One accumulation step under the current mode.
	always_comb begin
		logic                        first;
		logic signed [ACC_WIDTH-1:0] ax;
		logic signed [ACC_WIDTH-1:0] base;
		logic [ACC_WIDTH:0]          usum;
		logic [ACC_WIDTH:0]          ssum;
		first = (cnt_q == '0);
		ax    = $signed(mag);
		base  = $signed(acc_q);
		usum  = '0;
		ssum  = '0;
		acc_d = acc_q;
		case (mode)
			MODE_RSS: begin
				usum  = {1'b0, (first ? '0 : acc_q)} + {1'b0, sq_q};
				acc_d = usum[ACC_WIDTH] ? '1 : usum[ACC_WIDTH-1:0];
			end
			MODE_SUM: begin
				base  = first ? '0 : $signed(acc_q);
				ssum  = {base[ACC_WIDTH-1], base} + {x_q[ACC_WIDTH-1], x_q};
				if (ssum[ACC_WIDTH] != ssum[ACC_WIDTH-1]) begin
					acc_d = ssum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
				end else begin
					acc_d = ssum[ACC_WIDTH-1:0];
				end
			end
			default: begin
				base  = first ? ax : $signed(acc_q);
				acc_d = base;
				if (mode == MODE_MAX && x_q > base) begin
					acc_d = x_q;
				end else if (mode == MODE_MIN && x_q < base) begin
					acc_d = x_q;
				end else if (mode == MODE_ABSMAX && ax > base) begin
					acc_d = ax;
				end else if (mode == MODE_ABSMIN && ax < base) begin
					acc_d = ax;
				end
			end
		endcase
	end

	assign gend = vend_q ||
		(group_size != '0 && ({1'b0, cnt_q} + 1'b1) >= {1'b0, group_size});

	// Restoring square root, two radicand bits per step.
	assign rem_sh = {rem_q[REM_WIDTH-3:0], rad_q[ACC_WIDTH-1:ACC_WIDTH-2]};
	assign trial  = {1'b0, root_q, 2'b01};

	assign sat_acc = (acc_q[ACC_WIDTH-1:OUT_WIDTH-1] == '0 ||
		acc_q[ACC_WIDTH-1:OUT_WIDTH-1] == '1) ? acc_q[OUT_WIDTH-1:0] :
		(acc_q[ACC_WIDTH-1] ? OUT_MIN : OUT_MAX);
	assign sat_root = root_q[ROOT_WIDTH-1] ? OUT_MAX : OUT_WIDTH'(root_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q    <= {{(ACC_WIDTH-SAMPLE_WIDTH){in_data.sample[SAMPLE_WIDTH-1]}},
				in_data.sample};
			vend_q <= in_data.vector_end;
		end
		if (cmd.square) begin
			sq_q <= sq_d;
		end
		if (cmd.root_init) begin
			rad_q  <= acc_q;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[ACC_WIDTH-3:0], 2'b00};
			step_q <= step_q + 1'b1;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			out_q.reduced    <= (mode == MODE_RSS) ? sat_root : sat_acc;
			out_q.last_group <= vend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accum) begin
			acc_q <= acc_d;
			if (gend) begin
				cnt_q <= '0;
			end else if (cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign sts.group_end = gend;
	assign sts.rss       = (mode == MODE_RSS);
	assign sts.root_done = (step_q == STEP_WIDTH'(ROOT_STEPS - 1));
	assign out_data      = out_q;

endmodule

`default_nettype wire

// File: hdl/gsr_ctrl.sv
// Controller of the grouped stream reducer: sequences each sample through square and accumulate,
// and at a group end through root (rss mode only) and result load. Uses gsr_pkg and the assertion macros.
`default_nettype none
`include "grouped_stream_reducer_defines.svh"

module gsr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output gsr_pkg::dp_cmd_t          cmd,
	input  wire gsr_pkg::dp_status_t  sts
);
	import gsr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				if (!sts.group_end) begin
					state_d = ST_IDLE;
				end else if (sts.rss) begin
					state_d = ST_RINIT;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_RINIT: begin
				cmd.root_init = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`GSR_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid_q || out_ready), "result overwritten")
	`GSR_ASSERT(a_cmd_onehot, $onehot0(cmd), "datapath commands overlap")
	`GSR_ASSERT(a_root_only_rss, (state_q == ST_ROOT) |-> sts.rss, "root outside rss mode")
	`GSR_ASSERT(a_accept_then_square, (in_valid && in_ready) |=> (state_q == ST_SQUARE), "accept did not advance")

endmodule

`default_nettype wire
